@@ rtl/line_min_max_window_filter_unit_macros.svh @@
// assertion macros used by the top rtl file
`ifndef LINE_MIN_MAX_WINDOW_FILTER_UNIT_MACROS_SVH
`define LINE_MIN_MAX_WINDOW_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define LMMWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LMMWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LMMWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define LMMWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/lmmwf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lmmwf_pkg;

   localparam int MAX_RADIUS = 64;
   localparam int RING_DEPTH = 128;
   localparam int POS_BITS   = 16;

   localparam int RING_BITS  = $clog2(RING_DEPTH);
   localparam int EFF_RADIUS_MAX = (MAX_RADIUS < RING_DEPTH / 2) ? MAX_RADIUS : RING_DEPTH / 2;

   localparam int RAD_BITS   = 7;
   localparam int CHAN_BITS  = 16;
   localparam int LEVEL_BITS = 16;
   localparam int PIX_BITS   = 4 * CHAN_BITS;
   localparam int ACC_BITS   = 32;
   localparam int COEF_BITS  = 16;

   localparam logic [COEF_BITS-1:0] WEIGHT_RED   = 16'd19589;
   localparam logic [COEF_BITS-1:0] WEIGHT_GREEN = 16'd38444;
   localparam logic [COEF_BITS-1:0] WEIGHT_BLUE  = 16'd7503;
   localparam logic [ACC_BITS-1:0]  LUMA_ROUND   = 32'd32768;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_RADIUS         = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_TAKE_MIN       = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_SELECT = 2'd2;

   typedef struct packed {
      logic [RAD_BITS-1:0] radius;
      logic                take_min;
      logic                channel_select;
   } cfg_type;

   // luma weight for multiply step 0 (red), 1 (green), 2 (blue)
   function automatic logic [COEF_BITS-1:0] luma_coef(input logic [1:0] step);
      logic [COEF_BITS-1:0] c;
      case (step)
         2'd0: c = WEIGHT_RED;
         2'd1: c = WEIGHT_GREEN;
         2'd2: c = WEIGHT_BLUE;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [RAD_BITS-1:0] eff_radius(input logic [RAD_BITS-1:0] r);
      logic [RAD_BITS-1:0] cap;
      cap = RAD_BITS'(EFF_RADIUS_MAX);
      return (r > cap) ? cap : r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lmmwf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lmmwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/lmmwf_luma.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lmmwf_luma (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0] red,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0] green,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0] blue,
   output logic                                 done,
   output logic [lmmwf_pkg::LEVEL_BITS-1:0]     level
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [1:0]                         step_ff, step_in;
   logic [lmmwf_pkg::ACC_BITS-1:0]     prod_ff, prod_in;
   logic [lmmwf_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic [lmmwf_pkg::CHAN_BITS-1:0]    operand;

   always_comb begin
      case (step_ff)
         2'd0: operand = red;
         2'd1: operand = green;
         2'd2: operand = blue;
         default: operand = '0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         acc_in  = lmmwf_pkg::LUMA_ROUND;
      end else if (busy_ff) begin
         // one multiply per cycle, accumulate the previous product
         prod_in = lmmwf_pkg::luma_coef(step_ff) * operand;
         if (step_ff != 2'd0) begin
            acc_in = acc_ff + prod_ff;
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done  = done_ff;
   assign level = acc_ff[lmmwf_pkg::ACC_BITS-1 -: lmmwf_pkg::LEVEL_BITS];

endmodule

`default_nettype wire

@@ rtl/lmmwf_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lmmwf_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [lmmwf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [lmmwf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [lmmwf_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                     pready,
   output lmmwf_pkg::cfg_type                       cfg
);

   lmmwf_pkg::cfg_type               cfg_ff, cfg_in;
   logic [lmmwf_pkg::REG_IDX_BITS-1:0] idx;
   logic                               wr;

   assign idx = paddr[lmmwf_pkg::CSR_ADDR_BITS-1:2];
   assign wr  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            lmmwf_pkg::REG_RADIUS: begin
               cfg_in.radius = pwdata[lmmwf_pkg::RAD_BITS-1:0];
            end
            lmmwf_pkg::REG_TAKE_MIN: begin
               cfg_in.take_min = pwdata[0];
            end
            lmmwf_pkg::REG_CHANNEL_SELECT: begin
               cfg_in.channel_select = pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         lmmwf_pkg::REG_RADIUS: begin
            prdata = lmmwf_pkg::CSR_DATA_BITS'(cfg_ff.radius);
         end
         lmmwf_pkg::REG_TAKE_MIN: begin
            prdata = lmmwf_pkg::CSR_DATA_BITS'(cfg_ff.take_min);
         end
         lmmwf_pkg::REG_CHANNEL_SELECT: begin
            prdata = lmmwf_pkg::CSR_DATA_BITS'(cfg_ff.channel_select);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/line_min_max_window_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   pix_red/green/blue/alpha, end_of_line
// rsp      out        rsp_valid/rsp_stall   out_red/green/blue/alpha, line_done
// csr      in         apb write/read        radius, take_min, channel_select
//
// one pixel beat: accept, luma multiply (skipped in alpha mode), ring write
// each result: window check, on a rescan up to 2*radius-1 further level ring reads,
// then own and winner pixel ring reads; req_stall stays high throughout
// one level compare per cycle in a single shared comparator picks the best level entry
// a result waits in the output register while the next pixel beat is taken
// synchronous reset clears state, positions, best index and valid flags; rings start unwritten

`include "line_min_max_window_filter_unit_macros.svh"

module line_min_max_window_filter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0]     req_pix_red,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0]     req_pix_green,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0]     req_pix_blue,
   input  wire logic [lmmwf_pkg::CHAN_BITS-1:0]     req_pix_alpha,
   input  wire logic                                req_end_of_line,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [lmmwf_pkg::CHAN_BITS-1:0]     rsp_out_red,
   output logic      [lmmwf_pkg::CHAN_BITS-1:0]     rsp_out_green,
   output logic      [lmmwf_pkg::CHAN_BITS-1:0]     rsp_out_blue,
   output logic      [lmmwf_pkg::CHAN_BITS-1:0]     rsp_out_alpha,
   output logic                                     rsp_line_done,

   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lmmwf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [lmmwf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [lmmwf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                     csr_pready
);

   localparam int PB = lmmwf_pkg::POS_BITS;
   localparam int RB = lmmwf_pkg::RING_BITS;
   localparam int CB = lmmwf_pkg::CHAN_BITS;
   localparam int LB = lmmwf_pkg::LEVEL_BITS;
   localparam int XB = lmmwf_pkg::PIX_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LUMA  = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_OWN   = 4'd5;
   localparam logic [3:0] S_WIN   = 4'd6;
   localparam logic [3:0] S_FORM  = 4'd7;

   lmmwf_pkg::cfg_type cfg;

   logic [3:0]    state_ff, state_in;
   logic [CB-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in, alpha_ff, alpha_in;
   logic          eol_ff, eol_in;
   logic [LB-1:0] level_ff, level_in;
   logic [PB-1:0] in_pos_ff, in_pos_in, out_pos_ff, out_pos_in, last_ff, last_in;
   logic [PB-1:0] best_idx_ff, best_idx_in;
   logic          best_valid_ff, best_valid_in;
   logic [LB-1:0] best_level_ff, best_level_in;
   logic [PB-1:0] k0_ff, k0_in;
   logic [RB-1:0] span_ff, span_in, scan_i_ff, scan_i_in;
   logic          cmp_valid_ff, cmp_valid_in, cmp_force_ff, cmp_force_in;
   logic [PB-1:0] cmp_idx_ff, cmp_idx_in;
   logic          done_flag_ff, done_flag_in;
   logic [XB-1:0] own_ff, own_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0] rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [CB-1:0] rsp_blue_ff, rsp_blue_in, rsp_alpha_ff, rsp_alpha_in;
   logic          rsp_done_ff, rsp_done_in;

   logic          accept, luma_start, luma_done;
   logic [LB-1:0] luma_level;

   logic          pix_we, pix_re, lvl_re;
   logic [RB-1:0] pix_raddr, lvl_raddr;
   logic [XB-1:0] pix_rdata;
   logic [LB-1:0] lvl_rdata;

   logic [lmmwf_pkg::RAD_BITS-1:0] r_eff;
   logic [PB-1:0] r_pos, rr_pos, pend, k0, k1, ahead, span, scan_idx;
   logic          stop, in_win, replaces, load;

   lmmwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lmmwf_luma u_luma (
      .clock (clock),
      .reset (reset),
      .start (luma_start),
      .red   (red_ff),
      .green (green_ff),
      .blue  (blue_ff),
      .done  (luma_done),
      .level (luma_level)
   );

   lmmwf_ram #(.WIDTH(XB), .DEPTH(lmmwf_pkg::RING_DEPTH)) u_pixel_ring (
      .clock (clock),
      .we    (pix_we),
      .waddr (in_pos_ff[RB-1:0]),
      .wdata ({alpha_ff, blue_ff, green_ff, red_ff}),
      .re    (pix_re),
      .raddr (pix_raddr),
      .rdata (pix_rdata)
   );

   lmmwf_ram #(.WIDTH(LB), .DEPTH(lmmwf_pkg::RING_DEPTH)) u_level_ring (
      .clock (clock),
      .we    (pix_we),
      .waddr (in_pos_ff[RB-1:0]),
      .wdata (level_ff),
      .re    (lvl_re),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // window bounds for the result at out_pos
   always_comb begin
      r_eff  = lmmwf_pkg::eff_radius(cfg.radius);
      r_pos  = PB'(r_eff);
      rr_pos = (r_eff == '0) ? PB'(1) : r_pos;
      pend   = in_pos_ff - out_pos_ff;
      stop   = (pend == '0) || (!eol_ff && (pend < rr_pos));
      k0     = (out_pos_ff < r_pos) ? '0 : out_pos_ff - r_pos;
      ahead  = last_ff - out_pos_ff;
      k1     = (ahead > rr_pos - PB'(1)) ? out_pos_ff + rr_pos - PB'(1) : last_ff;
      span   = k1 - k0;
      in_win = best_valid_ff && ((best_idx_ff - k0) <= span);
      scan_idx = k0_ff + PB'(scan_i_ff);
      replaces = cfg.take_min ? (best_level_ff >= lvl_rdata) : (best_level_ff <= lvl_rdata);
   end

   always_comb begin
      state_in      = state_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      alpha_in      = alpha_ff;
      eol_in        = eol_ff;
      level_in      = level_ff;
      in_pos_in     = in_pos_ff;
      out_pos_in    = out_pos_ff;
      last_in       = last_ff;
      best_idx_in   = best_idx_ff;
      best_valid_in = best_valid_ff;
      best_level_in = best_level_ff;
      k0_in         = k0_ff;
      span_in       = span_ff;
      scan_i_in     = scan_i_ff;
      cmp_valid_in  = 1'b0;
      cmp_force_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      done_flag_in  = done_flag_ff;
      own_in        = own_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_alpha_in  = rsp_alpha_ff;
      rsp_done_in   = rsp_done_ff;
      luma_start    = 1'b0;
      pix_we        = 1'b0;
      pix_re        = 1'b0;
      pix_raddr     = out_pos_ff[RB-1:0];
      lvl_re        = 1'b0;
      lvl_raddr     = k0[RB-1:0];
      load          = 1'b0;

      // level compare of the entry read in the previous cycle
      if (cmp_valid_ff && (cmp_force_ff || replaces)) begin
         best_idx_in   = cmp_idx_ff;
         best_level_in = lvl_rdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               red_in   = req_pix_red;
               green_in = req_pix_green;
               blue_in  = req_pix_blue;
               alpha_in = req_pix_alpha;
               eol_in   = req_end_of_line;
               if (cfg.channel_select) begin
                  level_in = req_pix_alpha;
                  state_in = S_WRITE;
               end else begin
                  state_in = S_LUMA;
               end
            end
         end
         S_LUMA: begin
            // start pulses with the accepted beat, done ends the wait
            if (luma_done) begin
               level_in = luma_level;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            pix_we    = 1'b1;
            last_in   = in_pos_ff;
            in_pos_in = in_pos_ff + PB'(1);
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (stop) begin
               if (eol_ff) begin
                  in_pos_in     = '0;
                  out_pos_in    = '0;
                  best_idx_in   = '0;
                  best_valid_in = 1'b0;
               end
               state_in = S_IDLE;
            end else begin
               done_flag_in = eol_ff && (pend == PB'(1));
               k0_in        = k0;
               span_in      = (span > PB'(lmmwf_pkg::RING_DEPTH - 1))
                            ? RB'(lmmwf_pkg::RING_DEPTH - 1) : span[RB-1:0];
               lvl_re       = 1'b1;
               cmp_valid_in = 1'b1;
               if (in_win) begin
                  lvl_raddr  = k1[RB-1:0];
                  cmp_idx_in = k1;
                  state_in   = S_OWN;
               end else begin
                  lvl_raddr     = k0[RB-1:0];
                  cmp_idx_in    = k0;
                  cmp_force_in  = 1'b1;
                  best_valid_in = 1'b1;
                  scan_i_in     = RB'(1);
                  state_in      = (span == '0) ? S_OWN : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            lvl_re       = 1'b1;
            lvl_raddr    = scan_idx[RB-1:0];
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_idx;
            scan_i_in    = scan_i_ff + RB'(1);
            if (scan_i_ff == span_ff) begin
               state_in = S_OWN;
            end
         end
         S_OWN: begin
            pix_re    = 1'b1;
            pix_raddr = out_pos_ff[RB-1:0];
            state_in  = S_WIN;
         end
         S_WIN: begin
            pix_re    = 1'b1;
            pix_raddr = best_idx_ff[RB-1:0];
            own_in    = pix_rdata;
            state_in  = S_FORM;
         end
         S_FORM: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               if (cfg.channel_select) begin
                  rsp_red_in   = own_ff[CB-1:0];
                  rsp_green_in = own_ff[2*CB-1:CB];
                  rsp_blue_in  = own_ff[3*CB-1:2*CB];
                  rsp_alpha_in = pix_rdata[4*CB-1:3*CB];
               end else begin
                  rsp_red_in   = pix_rdata[CB-1:0];
                  rsp_green_in = pix_rdata[2*CB-1:CB];
                  rsp_blue_in  = pix_rdata[3*CB-1:2*CB];
                  rsp_alpha_in = own_ff[4*CB-1:3*CB];
               end
               rsp_done_in = done_flag_ff;
               out_pos_in  = out_pos_ff + PB'(1);
               state_in    = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_IDLE && accept && !cfg.channel_select) begin
         luma_start = 1'b1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_pos_ff     <= '0;
         out_pos_ff    <= '0;
         best_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_pos_ff     <= in_pos_in;
         out_pos_ff    <= out_pos_in;
         best_idx_ff   <= best_idx_in;
         best_valid_ff <= best_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      alpha_ff      <= alpha_in;
      eol_ff        <= eol_in;
      level_ff      <= level_in;
      last_ff       <= last_in;
      best_level_ff <= best_level_in;
      k0_ff         <= k0_in;
      span_ff       <= span_in;
      scan_i_ff     <= scan_i_in;
      cmp_force_ff  <= cmp_force_in;
      cmp_idx_ff    <= cmp_idx_in;
      done_flag_ff  <= done_flag_in;
      own_ff        <= own_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_alpha_ff  <= rsp_alpha_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;
   assign rsp_line_done = rsp_done_ff;

   `LMMWF_ASSERT_IMP(a_cmp_only_after_read, clock, reset, cmp_valid_ff,
      (state_ff == S_SCAN) || (state_ff == S_OWN), "level compare outside window search")
   `LMMWF_ASSERT_NXT(a_write_advances, clock, reset, state_ff == S_WRITE,
      (in_pos_ff == $past(in_pos_ff) + PB'(1)) && (state_ff == S_CHECK),
      "ring write did not advance input position")
   `LMMWF_ASSERT_IMP(a_best_known_at_win, clock, reset, state_ff == S_WIN, best_valid_ff,
      "winner read without a valid best index")
   `LMMWF_ASSERT_NXT(a_form_holds_when_full, clock, reset,
      (state_ff == S_FORM) && rsp_valid_ff && rsp_stall,
      (state_ff == S_FORM) && rsp_valid_ff, "result overwrote a waiting beat")

endmodule

`default_nettype wire
